// File: rtl/bimap_pkg.sv
`timescale 1ns / 1ps

package bimap_pkg;

	localparam int BIM_DEPTH = 64;
	localparam int ID_W      = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic            valid;
		logic            kind;
		logic [ID_W-1:0] client;
		logic [ID_W-1:0] fsid;
	} entry_t;

	typedef struct packed {
		logic load_in;
		logic clr_cnt;
		logic step;
		logic rd;
		logic wipe;
		logic finish;
	} bimap_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic op_clear;
		logic out_free;
	} bimap_sts_t;

endpackage

// File: rtl/bimap_ctrl.sv
`timescale 1ns / 1ps

module bimap_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bimap_pkg::bimap_sts_t sts,
	output bimap_pkg::bimap_cmd_t cmd
);
	import bimap_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					if (sts.cnt_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.cnt_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.load_in = (state_q == S_IDLE) && in_valid;
		cmd.clr_cnt = cmd.load_in;
		cmd.step    = (state_q == S_INIT) || (state_q == S_SCAN);
		cmd.rd      = (state_q == S_SCAN) && !sts.op_clear;
		cmd.wipe    = (state_q == S_INIT) || ((state_q == S_SCAN) && sts.op_clear);
		cmd.finish  = (state_q == S_FINISH) && sts.out_free;
	end

	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == S_SCAN))
		else $error("accepted item did not start a scan");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && sts.cnt_last) |=> (state_q == S_DRAIN))
		else $error("scan end did not drain");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE))
		else $error("finish did not return to idle");

endmodule

// File: rtl/bimap_dp.sv
`timescale 1ns / 1ps

module bimap_dp #(
	parameter int TABLE_DEPTH = bimap_pkg::BIM_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bimap_pkg::bimap_cmd_t     cmd,
	output bimap_pkg::bimap_sts_t     sts,
	input  logic [1:0]                opcode,
	input  logic                      id_kind,
	input  logic                      direction,
	input  logic [bimap_pkg::ID_W-1:0] cli_id,
	input  logic [bimap_pkg::ID_W-1:0] fs_id,
	input  logic [bimap_pkg::ID_W-1:0] key,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [bimap_pkg::ID_W-1:0] mapped_client_id,
	output logic [bimap_pkg::ID_W-1:0] mapped_fs_id
);
	import bimap_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

	entry_t          mem [TABLE_DEPTH];
	entry_t          rd_data_s1;
	logic            rvld_s1;
	logic [AW-1:0]   raddr_s1;
	logic [AW-1:0]   cnt_q;

	op_t             op_q;
	logic            kind_q;
	logic            dir_q;
	logic [ID_W-1:0] cl_q;
	logic [ID_W-1:0] fs_q;
	logic [ID_W-1:0] key_q;

	logic            have_slot_q;
	logic [AW-1:0]   slot_q;
	logic            hit_q;
	logic [ID_W-1:0] found_cl_q;
	logic [ID_W-1:0] found_fs_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [ID_W-1:0] map_cl_q;
	logic [ID_W-1:0] map_fs_q;

	logic            kmatch;
	logic            cl_eq;
	logic            fs_eq;
	logic [ID_W-1:0] probe;
	logic            rm;
	logic            free;
	logic            lk_hit;
	logic            commit;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            out_free;

	assign out_free     = !out_valid_q || !out_stall;
	assign sts.cnt_last = (cnt_q == LAST);
	assign sts.op_clear = (op_q == OP_CLEAR);
	assign sts.out_free = out_free;

	always_comb begin
		kmatch = rvld_s1 && rd_data_s1.valid && (rd_data_s1.kind == kind_q);
		cl_eq  = (rd_data_s1.client == cl_q);
		fs_eq  = (rd_data_s1.fsid == fs_q);
		probe  = dir_q ? rd_data_s1.client : rd_data_s1.fsid;
		case (op_q)
			OP_INSERT: rm = kmatch && (cl_eq || fs_eq);
			OP_DELETE: rm = kmatch && cl_eq && fs_eq;
			default:   rm = 1'b0;
		endcase
		free   = rvld_s1 && (!rd_data_s1.valid || rm);
		lk_hit = (op_q == OP_LOOKUP) && kmatch && (probe == key_q);
		commit = cmd.finish && (op_q == OP_INSERT) && have_slot_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = '0;
		if (cmd.wipe) begin
			wr_en = 1'b1;
		end else if (rm) begin
			wr_en   = 1'b1;
			wr_addr = raddr_s1;
		end else if (commit) begin
			wr_en          = 1'b1;
			wr_addr        = slot_q;
			wr_data.valid  = 1'b1;
			wr_data.kind   = kind_q;
			wr_data.client = cl_q;
			wr_data.fsid   = fs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_data_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rvld_s1     <= 1'b0;
			have_slot_q <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvld_s1 <= cmd.rd;
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.step && (cnt_q != LAST)) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.load_in) begin
				have_slot_q <= 1'b0;
				hit_q       <= 1'b0;
			end else begin
				if (free) have_slot_q <= 1'b1;
				if (rm || lk_hit) hit_q <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= cnt_q;
		if (cmd.load_in) begin
			op_q   <= op_t'(opcode);
			kind_q <= id_kind;
			dir_q  <= direction;
			cl_q   <= cli_id;
			fs_q   <= fs_id;
			key_q  <= key;
		end
		if (free && !have_slot_q) slot_q <= raddr_s1;
		if (lk_hit && !hit_q) begin
			found_cl_q <= rd_data_s1.client;
			found_fs_q <= rd_data_s1.fsid;
		end
		if (cmd.finish) begin
			status_q <= ST_OK;
			map_cl_q <= '0;
			map_fs_q <= '0;
			case (op_q)
				OP_INSERT: begin
					if (have_slot_q) begin
						map_cl_q <= cl_q;
						map_fs_q <= fs_q;
					end else begin
						status_q <= ST_FULL;
					end
				end
				OP_DELETE: begin
					if (hit_q) begin
						map_cl_q <= cl_q;
						map_fs_q <= fs_q;
					end else begin
						status_q <= ST_MISS;
					end
				end
				OP_LOOKUP: begin
					if (hit_q) begin
						map_cl_q <= found_cl_q;
						map_fs_q <= found_fs_q;
					end else begin
						status_q <= ST_MISS;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign mapped_client_id = map_cl_q;
	assign mapped_fs_id     = map_fs_q;

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rm && (cmd.wipe || commit)))
		else $error("table write clash");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not presented after finish");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

endmodule

// File: rtl/bidirectional_id_map_table.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  opcode, id_kind, direction, cli_id, fs_id, key
// out      out_valid / out_stall status, mapped_client_id, mapped_fs_id
//
// Each item passes through accept, one table read per entry through the single read port,
// a drain of the read register and a commit.
// After reset the table is swept invalid entry by entry; no item is taken then.
// Clear sweeps the table the same way and takes the same time as any other item.
// A held result does not block acceptance; the next result waits for it to be taken.
module bidirectional_id_map_table #(
	parameter int TABLE_DEPTH = bimap_pkg::BIM_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic                       id_kind,
	input  logic                       direction,
	input  logic [bimap_pkg::ID_W-1:0] cli_id,
	input  logic [bimap_pkg::ID_W-1:0] fs_id,
	input  logic [bimap_pkg::ID_W-1:0] key,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [bimap_pkg::ID_W-1:0] mapped_client_id,
	output logic [bimap_pkg::ID_W-1:0] mapped_fs_id
);
	import bimap_pkg::*;

	bimap_cmd_t cmd;
	bimap_sts_t sts;

	bimap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bimap_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.opcode           (opcode),
		.id_kind          (id_kind),
		.direction        (direction),
		.cli_id           (cli_id),
		.fs_id            (fs_id),
		.key              (key),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.mapped_client_id (mapped_client_id),
		.mapped_fs_id     (mapped_fs_id)
	);

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import bimap_pkg::*;

	localparam int DEPTH        = BIM_DEPTH;
	localparam int RANDOM_ITEMS = 550;

	typedef logic [ID_W-1:0] id_t;

	typedef struct packed {
		op_t  op;
		logic kind;
		logic dir;
		id_t  cl;
		id_t  fs;
		id_t  key;
	} map_req_t;

	typedef struct packed {
		status_t st;
		id_t     cl;
		id_t     fs;
	} map_result_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [1:0] opcode    = '0;
	logic       id_kind   = 1'b0;
	logic       direction = 1'b0;
	id_t        cli_id    = '0;
	id_t        fs_id     = '0;
	id_t        key       = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	id_t        mapped_client_id;
	id_t        mapped_fs_id;

	bidirectional_id_map_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.id_kind(id_kind),
		.direction(direction),
		.cli_id(cli_id),
		.fs_id(fs_id),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.mapped_client_id(mapped_client_id),
		.mapped_fs_id(mapped_fs_id)
	);

	always #5 clk = ~clk;

	// shadow copy of the mapping table
	logic tbl_valid  [DEPTH];
	logic tbl_kind   [DEPTH];
	id_t  tbl_client [DEPTH];
	id_t  tbl_fs     [DEPTH];

	map_req_t    stim_q [$];
	map_req_t    known_q [$];
	map_result_t pending_q [$];
	map_req_t    next_req;
	map_result_t want;
	id_t         id_pool [24];

	logic in_taken = 1'b0;
	int   total_items = 1;
	int   sent_cnt = 0;
	int   accepted_cnt = 0;
	int   result_cnt = 0;
	int   errors = 0;
	int   op_cnt [4] = '{0, 0, 0, 0};
	int   status_cnt [3] = '{0, 0, 0};

	function automatic map_result_t apply_map_op(map_req_t r);
		map_result_t res;
		int slot;
		bit hit;
		res.st = ST_OK;
		res.cl = '0;
		res.fs = '0;
		case (r.op)
		OP_INSERT: begin
			slot = -1;
			for (int i = 0; i < DEPTH; i++) begin
				if (tbl_valid[i] && tbl_kind[i] == r.kind &&
						(tbl_fs[i] == r.fs || tbl_client[i] == r.cl))
					tbl_valid[i] = 1'b0;
				if (!tbl_valid[i] && slot < 0)
					slot = i;
			end
			if (slot < 0) begin
				res.st = ST_FULL;
			end else begin
				tbl_valid[slot]  = 1'b1;
				tbl_kind[slot]   = r.kind;
				tbl_client[slot] = r.cl;
				tbl_fs[slot]     = r.fs;
				res.cl = r.cl;
				res.fs = r.fs;
			end
		end
		OP_DELETE: begin
			hit = 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				if (tbl_valid[i] && tbl_kind[i] == r.kind &&
						tbl_client[i] == r.cl && tbl_fs[i] == r.fs) begin
					tbl_valid[i] = 1'b0;
					hit = 1'b1;
				end
			end
			if (hit) begin
				res.cl = r.cl;
				res.fs = r.fs;
			end else begin
				res.st = ST_MISS;
			end
		end
		OP_LOOKUP: begin
			res.st = ST_MISS;
			for (int i = 0; i < DEPTH; i++) begin
				if (res.st == ST_MISS && tbl_valid[i] && tbl_kind[i] == r.kind &&
						(r.dir ? tbl_client[i] : tbl_fs[i]) == r.key) begin
					res.st = ST_OK;
					res.cl = tbl_client[i];
					res.fs = tbl_fs[i];
				end
			end
		end
		default: begin
			for (int i = 0; i < DEPTH; i++)
				tbl_valid[i] = 1'b0;
		end
		endcase
		return res;
	endfunction

	function automatic id_t pick_id();
		if ($urandom_range(0, 99) < 70)
			return id_pool[$urandom_range(0, 23)];
		return $urandom;
	endfunction

	function automatic int idle_pct(bit sender);
		int ph;
		ph = sent_cnt * 3 / total_items;
		if (ph == 0)
			return sender ? 18 : 49;
		if (ph == 1)
			return sender ? 49 : 18;
		return 0;
	endfunction

	task automatic add_item(op_t op, logic k, logic d, id_t c, id_t f, id_t y);
		map_req_t r;
		r = '{op, k, d, c, f, y};
		stim_q.push_back(r);
		if (op == OP_INSERT) begin
			known_q.push_back(r);
			if (known_q.size() > 128)
				void'(known_q.pop_front());
		end
	endtask

	task automatic report_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// hold a stalled item, advance when taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
				next_req = stim_q.pop_front();
				opcode    <= next_req.op;
				id_kind   <= next_req.kind;
				direction <= next_req.dir;
				cli_id    <= next_req.cl;
				fs_id     <= next_req.fs;
				key       <= next_req.key;
				in_valid  <= 1'b1;
				sent_cnt  <= sent_cnt + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < idle_pct(1'b0));
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				pending_q.push_back(apply_map_op('{op_t'(opcode), id_kind, direction,
					cli_id, fs_id, key}));
				op_cnt[opcode]++;
				accepted_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					report_error($sformatf("unexpected result status=%0d client=%h fs=%h",
						status, mapped_client_id, mapped_fs_id));
				end else begin
					want = pending_q.pop_front();
					if (status !== want.st || mapped_client_id !== want.cl ||
							mapped_fs_id !== want.fs)
						report_error($sformatf({"result %0d: expected status=%0d client=%h ",
							"fs=%h, got status=%0d client=%h fs=%h"}, result_cnt,
							want.st, want.cl, want.fs, status, mapped_client_id,
							mapped_fs_id));
					status_cnt[int'(want.st)]++;
					result_cnt++;
				end
			end
		end
	end

	initial begin
		map_req_t k;
		int n_rand, fills, base, sel, cycles, limit;
		logic kd, d;
		for (int i = 0; i < DEPTH; i++)
			tbl_valid[i] = 1'b0;
		foreach (id_pool[i])
			id_pool[i] = $urandom;
		id_pool[0] = '0;
		id_pool[1] = '1;

		add_item(OP_LOOKUP, 1'b0, 1'b0, $urandom, $urandom, '0);
		add_item(OP_DELETE, 1'b1, 1'b1, '0, '0, $urandom);
		add_item(OP_INSERT, 1'b0, 1'b0, '0, '0, '1);
		add_item(OP_INSERT, 1'b0, 1'b1, '1, '1, '0);
		add_item(OP_INSERT, 1'b1, 1'b0, '0, '1, $urandom);
		add_item(OP_LOOKUP, 1'b0, 1'b0, '0, '0, '1);
		add_item(OP_LOOKUP, 1'b0, 1'b1, '1, '1, '0);
		add_item(OP_LOOKUP, 1'b1, 1'b1, $urandom, $urandom, '0);
		add_item(OP_LOOKUP, 1'b1, 1'b0, $urandom, $urandom, '0);
		add_item(OP_INSERT, 1'b0, 1'b0, 32'd5, '0, $urandom);
		add_item(OP_LOOKUP, 1'b0, 1'b1, $urandom, $urandom, '0);
		add_item(OP_INSERT, 1'b0, 1'b1, 32'd5, 32'd7, $urandom);
		add_item(OP_LOOKUP, 1'b0, 1'b0, $urandom, $urandom, '0);
		add_item(OP_INSERT, 1'b0, 1'b0, 32'd5, 32'd7, $urandom);
		add_item(OP_DELETE, 1'b0, 1'b0, 32'd5, 32'd8, $urandom);
		add_item(OP_DELETE, 1'b1, 1'b1, 32'd5, 32'd7, $urandom);
		add_item(OP_DELETE, 1'b0, 1'b0, 32'd5, 32'd7, $urandom);
		add_item(OP_LOOKUP, 1'b0, 1'b1, $urandom, $urandom, 32'd5);
		add_item(OP_INSERT, 1'b0, 1'($urandom_range(0, 1)), '1, 32'd1, $urandom);
		add_item(OP_CLEAR, 1'b1, 1'b1, $urandom, $urandom, $urandom);
		add_item(OP_LOOKUP, 1'b0, 1'b1, $urandom, $urandom, '1);
		add_item(OP_LOOKUP, 1'b1, 1'b1, $urandom, $urandom, '0);
		add_item(OP_INSERT, 1'b1, 1'b1, '1, '0, $urandom);

		n_rand = 0;
		fills = 0;
		while (n_rand < RANDOM_ITEMS) begin
			d = 1'($urandom_range(0, 1));
			kd = 1'($urandom_range(0, 1));
			if ((fills == 0 && n_rand >= 120) || (fills == 1 && n_rand >= 340)) begin
				fills++;
				base = stim_q.size();
				add_item(OP_CLEAR, kd, d, $urandom, $urandom, $urandom);
				for (int i = 0; i < DEPTH + 4; i++)
					add_item(OP_INSERT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom, $urandom, $urandom);
				k = stim_q[base + 1];
				add_item(OP_INSERT, k.kind, d, k.cl, k.fs, $urandom);
				k = stim_q[base + 2];
				add_item(OP_INSERT, k.kind, d, $urandom, k.fs, $urandom);
				k = stim_q[base + 3];
				add_item(OP_INSERT, k.kind, d, k.cl, $urandom, $urandom);
				for (int i = 0; i < 8; i++) begin
					k = stim_q[base + 1 + $urandom_range(0, DEPTH + 3)];
					d = 1'($urandom_range(0, 1));
					add_item(OP_LOOKUP, k.kind, d, $urandom, $urandom, d ? k.cl : k.fs);
				end
				for (int i = 0; i < 4; i++) begin
					k = stim_q[base + 4 + $urandom_range(0, DEPTH - 8)];
					add_item(OP_DELETE, k.kind, d, k.cl, k.fs, $urandom);
				end
				n_rand += stim_q.size() - base;
			end else begin
				sel = $urandom_range(0, 99);
				k = known_q[$urandom_range(0, known_q.size() - 1)];
				if (sel < 40)
					add_item(OP_INSERT, kd, d, pick_id(), pick_id(), $urandom);
				else if (sel < 50)
					add_item(OP_DELETE, k.kind, d, k.cl, k.fs, $urandom);
				else if (sel < 56)
					add_item(OP_DELETE, k.kind, d, k.cl, pick_id(), $urandom);
				else if (sel < 80)
					add_item(OP_LOOKUP, ($urandom_range(0, 9) == 0) ? !k.kind : k.kind, d,
						$urandom, $urandom, d ? k.cl : k.fs);
				else if (sel < 97)
					add_item(OP_LOOKUP, kd, d, $urandom, $urandom, pick_id());
				else
					add_item(OP_CLEAR, kd, d, $urandom, $urandom, $urandom);
				n_rand++;
			end
		end
		total_items = stim_q.size();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		limit = 2 * DEPTH + total_items * (DEPTH + 3) * 6 + 1000;
		cycles = 0;
		while ((accepted_cnt < total_items || pending_q.size() != 0) && cycles < limit) begin
			@(negedge clk);
			cycles++;
		end
		repeat (DEPTH + 8) @(negedge clk);

		if (accepted_cnt < total_items || pending_q.size() != 0)
			report_error($sformatf("timeout: %0d of %0d items taken, %0d results outstanding",
				accepted_cnt, total_items, pending_q.size()));

		$display("Ran %0d items: %0d inserts, %0d deletes, %0d lookups, %0d clears",
			accepted_cnt, op_cnt[OP_INSERT], op_cnt[OP_DELETE], op_cnt[OP_LOOKUP],
			op_cnt[OP_CLEAR]);
		$display("Checked %0d results: %0d done or found, %0d not found, %0d table full",
			result_cnt, status_cnt[ST_OK], status_cnt[ST_MISS], status_cnt[ST_FULL]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/bimap_pkg.sv
rtl/bimap_ctrl.sv
rtl/bimap_dp.sv
rtl/bidirectional_id_map_table.sv
verif/tb.sv
